// ----- sv/ifla_pkg.sv -----
`default_nettype none
package ifla_pkg;
    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 4;
    localparam int AW = 12;
    localparam int SW = 13;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_ZERO    = 3'd1;
    localparam t_status ST_LARGE   = 3'd2;
    localparam t_status ST_NOSPACE = 3'd3;
    localparam t_status ST_NULL    = 3'd4;
    localparam t_status ST_RANGE   = 3'd5;
    localparam t_status ST_FREED   = 3'd6;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] req_bytes;
        logic [11:0] free_offset;
    } t_cmd;

    typedef struct packed {
        logic [11:0] payload_offset;
        t_status     status;
    } t_rsp;
endpackage
`default_nettype wire

// ----- sv/ifla_if.sv -----
`default_nettype none
interface ifla_cmd_if (input wire logic i_clk);
    logic valid;
    logic ready;
    ifla_pkg::t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ifla_rsp_if (input wire logic i_clk);
    logic valid;
    logic ready;
    ifla_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/ifla_hdr_ram.sv -----
`default_nettype none
// Header store: one write port, one registered read port.
// Entry = {alloc flag, 12-bit size}; bit 12 of the size is never needed at 4 KiB.
module ifla_hdr_ram (
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic [ifla_pkg::AW-1:0] i_waddr,
    input  wire logic [ifla_pkg::SW-1:0] i_wdata,
    input  wire logic [ifla_pkg::AW-1:0] i_raddr,
    output logic      [ifla_pkg::SW-1:0] o_rdata
);
    import ifla_pkg::*;
    logic [SW-1:0] r_mem [HEAP_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- sv/implicit_free_list_allocator.sv -----
`default_nettype none
// First-fit heap allocator over a 4 KiB byte heap with 4-byte block headers.
// Channels: i_cmd (sink) carries cmd, req_bytes and free_offset; o_rsp
// (source) carries payload_offset and status, one response transaction per
// command transaction. Both use valid/ready; a transaction completes on a
// rising edge with valid and ready high.
// Walk: allocate visits block headers through the header RAM (one write
// port, one registered read port), issuing each address and then checking
// the registered read data, followed by the carve writes. Free does the same
// walk for its merge pass over every block in the heap. One command is in
// flight at a time.
// Size and offset errors answer without a walk.
// Reset: a clearing pass writes zero to all 4096 header entries, one per
// cycle, then the single free block header; i_cmd.ready stays low until
// that header is written.
// Stall: the response sits in the output register until taken. The next
// command is still accepted and walked meanwhile; only its response waits
// in S_RESP until the output register is free.
module implicit_free_list_allocator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ifla_cmd_if.sink   i_cmd,
    ifla_rsp_if.source o_rsp
);
    import ifla_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_INIT, S_IDLE, S_ARD, S_ACHK, S_AWR2,
        S_FCHK, S_MRD_C, S_MRD_N, S_MCHK, S_MRD_N2, S_RESP
    } t_state;

    t_state        r_state;
    logic [AW:0]   r_clr;
    logic [15:0]   r_req;
    logic [AW-1:0] r_off;
    logic [AW+1:0] r_p;       // walk pointer, wide enough to pass heap end
    logic [AW+1:0] r_nxt;
    logic          r_cur_used;
    logic [AW:0]   r_cur_size;
    logic [AW-1:0] r_q;
    t_rsp          r_rsp;     // result of the command being worked on
    t_rsp          r_out;     // response on offer
    logic          r_rsp_valid;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [SW-1:0] ram_wdata, ram_rdata;

    ifla_hdr_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    localparam logic [AW+1:0] HEAP_END = (AW+2)'(HEAP_BYTES);
    localparam logic [AW+1:0] HDR      = (AW+2)'(HEADER_BYTES);

    logic          rd_used;
    logic [AW:0]   rd_size;
    logic [AW+1:0] step_p;
    logic [AW:0]   want;
    logic [AW:0]   remain;
    logic [AW:0]   merged;

    assign rd_used = ram_rdata[SW-1];
    assign rd_size = {1'b0, ram_rdata[AW-1:0]};
    assign step_p  = r_p + {1'b0, rd_size} + HDR;
    assign want    = r_req[AW:0];
    assign remain  = rd_size - want;
    assign merged  = r_cur_size + rd_size + HDR[AW:0];

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_out;

    // RAM port drive, decoded from state
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_p[AW-1:0];
        ram_wdata = '0;
        ram_raddr = r_p[AW-1:0];
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr[AW-1:0];
            end
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(HEADER_BYTES);
                ram_wdata = SW'(HEAP_BYTES - HEADER_BYTES);
            end
            S_IDLE:  ram_raddr = (i_cmd.data.cmd == CMD_FREE) ? i_cmd.data.free_offset
                                                             : AW'(HEADER_BYTES);
            S_AWR2: begin
                ram_we    = 1'b1;
                ram_waddr = r_q;
                ram_wdata = {1'b1, r_req[AW-1:0]};
            end
            // cur header is on the read port; fetch the one after it
            S_MRD_N:  ram_raddr = step_p[AW-1:0];
            S_MRD_N2: ram_raddr = r_nxt[AW-1:0];
            default: ;
        endcase
        // writes issued from check states
        if (r_state == S_ACHK && !rd_used && {3'b0, rd_size} >= r_req) begin
            ram_we = 1'b1;
            if (remain <= HDR[AW:0]) begin
                ram_wdata = {1'b1, rd_size[AW-1:0]};
            end else begin
                ram_wdata = {1'b0, AW'(remain - HDR[AW:0])};
            end
        end
        if (r_state == S_FCHK && rd_used) begin
            ram_we    = 1'b1;
            ram_waddr = r_off;
            ram_wdata = {1'b0, ram_rdata[AW-1:0]};
        end
        if (r_state == S_MCHK && !r_cur_used && !rd_used) begin
            ram_we    = 1'b1;
            ram_waddr = r_p[AW-1:0];
            ram_wdata = {1'b0, merged[AW-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready && r_state != S_RESP) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(HEAP_BYTES - 1)) begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT: r_state <= S_IDLE;
                S_IDLE: begin
                    if (i_cmd.valid && i_cmd.ready) begin
                        r_req <= i_cmd.data.req_bytes;
                        r_off <= i_cmd.data.free_offset;
                        if (i_cmd.data.cmd == CMD_FREE) begin
                            r_p     <= {2'b0, i_cmd.data.free_offset};
                            r_state <= S_FCHK;
                            if (i_cmd.data.free_offset == '0) begin
                                r_rsp   <= '{payload_offset: '0, status: ST_NULL};
                                r_state <= S_RESP;
                            end else if (i_cmd.data.free_offset < AW'(HEADER_BYTES)) begin
                                r_rsp   <= '{payload_offset: '0, status: ST_RANGE};
                                r_state <= S_RESP;
                            end
                        end else begin
                            r_p     <= HDR;
                            r_state <= S_ACHK;
                            if ({1'b0, i_cmd.data.req_bytes} + 17'(HEADER_BYTES)
                                    > 17'(HEAP_BYTES)) begin
                                r_rsp   <= '{payload_offset: '0, status: ST_LARGE};
                                r_state <= S_RESP;
                            end else if (i_cmd.data.req_bytes == '0) begin
                                r_rsp   <= '{payload_offset: '0, status: ST_ZERO};
                                r_state <= S_RESP;
                            end
                        end
                    end
                end
                S_ARD: r_state <= S_ACHK;
                S_ACHK: begin
                    if (!rd_used && {3'b0, rd_size} >= r_req) begin
                        if (remain <= HDR[AW:0]) begin
                            r_rsp   <= '{payload_offset: r_p[AW-1:0], status: ST_OK};
                            r_state <= S_RESP;
                        end else begin
                            r_q     <= AW'(r_p + {1'b0, remain});
                            r_state <= S_AWR2;
                        end
                    end else if (step_p >= HEAP_END) begin
                        r_rsp   <= '{payload_offset: '0, status: ST_NOSPACE};
                        r_state <= S_RESP;
                    end else begin
                        r_p     <= step_p;
                        r_state <= S_ARD;
                    end
                end
                S_AWR2: begin
                    r_rsp   <= '{payload_offset: r_q, status: ST_OK};
                    r_state <= S_RESP;
                end
                S_FCHK: begin
                    if (!rd_used) begin
                        r_rsp   <= '{payload_offset: '0, status: ST_FREED};
                        r_state <= S_RESP;
                    end else begin
                        r_p     <= HDR;
                        r_state <= S_MRD_C;
                    end
                end
                S_MRD_C: r_state <= S_MRD_N;   // read of cur issued (raddr = r_p)
                S_MRD_N: begin
                    // cur data now valid
                    r_cur_used <= rd_used;
                    r_cur_size <= rd_size;
                    r_nxt      <= step_p;
                    if (step_p >= HEAP_END) begin
                        r_rsp   <= '{payload_offset: '0, status: ST_OK};
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_MCHK;
                    end
                end
                S_MCHK: begin
                    if (!r_cur_used && !rd_used) begin
                        r_cur_size <= merged;
                        r_nxt      <= r_p + {1'b0, merged} + HDR;
                        if (r_p + {1'b0, merged} + HDR >= HEAP_END) begin
                            r_rsp   <= '{payload_offset: '0, status: ST_OK};
                            r_state <= S_RESP;
                        end else begin
                            r_state <= S_MRD_N2;
                        end
                    end else begin
                        r_p        <= r_nxt;
                        r_cur_used <= rd_used;
                        r_cur_size <= rd_size;
                        r_nxt      <= r_nxt + {1'b0, rd_size} + HDR;
                        if (r_nxt + {1'b0, rd_size} + HDR >= HEAP_END) begin
                            r_rsp   <= '{payload_offset: '0, status: ST_OK};
                            r_state <= S_RESP;
                        end else begin
                            r_state <= S_MRD_N2;
                        end
                    end
                end
                S_MRD_N2: r_state <= S_MCHK;
                S_RESP: begin
                    // load the output register once the previous response is gone
                    if (!r_rsp_valid || o_rsp.ready) begin
                        r_out       <= r_rsp;
                        r_rsp_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
